// File: src/spr_pkg.sv
// package: types, codes and sizing shared by the sorted pair registry
`default_nettype none
package spr_pkg;

    // table size and derived widths
    localparam int CAPACITY  = 32;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int EVENT_W   = 8;
    localparam int ID_W      = 16;
    localparam int KEY_W     = EVENT_W + ID_W;
    localparam int COUNT_W   = 6;
    localparam int COUNT_MAX = 63;

    // request codes
    typedef enum logic [1:0] {
        ACT_BIND   = 2'd0,
        ACT_UNBIND = 2'd1,
        ACT_LIST   = 2'd2,
        ACT_COUNT  = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_INVALID  = 3'd1,
        STATUS_DUP      = 3'd2,
        STATUS_NOTFOUND = 3'd3,
        STATUS_FULL     = 3'd4
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;
        logic insert;
        logic remove;
        logic tok_start;
        logic tok_shift;
    } t_cell_cmd;

    // what a cell shows its neighbours
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             lt;
        logic             match;
        logic             tok;
    } t_link;

endpackage
`default_nettype wire

// File: src/spr_if.sv
// interfaces: request and result channels with valid/ready handshake
`default_nettype none

interface spr_req_if;
    import spr_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [EVENT_W-1:0] event_req;
    logic [ID_W-1:0]    plugin_id;

    modport source (output valid, output action, output event_req, output plugin_id,
                    input ready);
    modport sink   (input valid, input action, input event_req, input plugin_id,
                    output ready);
endinterface

interface spr_rsp_if;
    import spr_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [ID_W-1:0]    subscriber;
    logic               item_valid;
    logic [COUNT_W-1:0] subscriber_count;
    logic               last;

    modport source (output valid, output status, output subscriber, output item_valid,
                    output subscriber_count, output last, input ready);
    modport sink   (input valid, input status, input subscriber, input item_valid,
                    input subscriber_count, input last, output ready);
endinterface

`default_nettype wire

// File: src/spr_cell.sv
// one table cell: holds a pair, compares it and shifts with its neighbours
`default_nettype none
module spr_cell
    import spr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_cmd        i_cmd,
    input  wire logic             i_in_use,
    input  wire logic [KEY_W-1:0] i_req_key,
    input  wire t_link            i_left,
    input  wire t_link            i_right,
    output t_link                 o_link,
    output logic                  o_eq,
    output logic                  o_first,
    output logic                  o_final
);

    logic [KEY_W-1:0] r_key;
    logic             r_lt;
    logic             r_eq;
    logic             r_match;
    logic             r_tok;

    // compare flags, taken when a request word is accepted
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lt    <= i_in_use && (r_key < i_req_key);
            r_eq    <= i_in_use && (r_key == i_req_key);
            r_match <= i_in_use && (r_key[KEY_W-1:ID_W] == i_req_key[KEY_W-1:ID_W]);
        end
    end

    // stored pair: open a gap for an insert, close one for a remove
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !r_lt) begin
            r_key <= i_left.lt ? i_req_key : i_left.key;
        end else if (i_cmd.remove && !r_lt) begin
            r_key <= i_right.key;
        end
    end

    // list token, passed one cell up per emitted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_cmd.tok_start) begin
            r_tok <= r_match && !i_left.match;
        end else if (i_cmd.tok_shift) begin
            r_tok <= i_left.tok;
        end
    end

    assign o_link  = '{key: r_key, lt: r_lt, match: r_match, tok: r_tok};
    assign o_eq    = r_eq;
    assign o_first = r_match && !i_left.match;
    assign o_final = r_match && !i_right.match;

endmodule
`default_nettype wire

// File: src/sorted_pair_registry_top.sv
// top level: sorted pair registry built from a row of compare-and-shift cells
//
// The table holds CAPACITY (event, subscriber id) pairs in ascending order in a row
// of cells; every cell compares its pair with the request in the cycle the request
// word is accepted, and a bind or unbind then shifts the row by one place once the
// result register is free. Each request is first accepted and compared, then decided
// and updated. A list request then walks a token up the matching cells, and each cell
// in turn drives the result word. One request is in flight at a time; a finished result
// may wait in the output register while the next request is accepted. The table needs
// no clearing after reset: only the entries below the fill count take part.
`default_nettype none
module sorted_pair_registry_top
    import spr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spr_req_if.sink    i_req,
    spr_rsp_if.source  o_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LIST
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_used;
    logic [1:0]         r_action;
    logic [EVENT_W-1:0] r_event;
    logic [ID_W-1:0]    r_id;

    logic               r_out_valid;
    t_status            r_status;
    logic [ID_W-1:0]    r_sub;
    logic               r_item_valid;
    logic [COUNT_W-1:0] r_count;
    logic               r_last;

    t_state             n_state;
    logic [CNT_W-1:0]   n_used;
    logic               n_out_valid;
    t_status            n_status;
    logic [ID_W-1:0]    n_sub;
    logic               n_item_valid;
    logic [COUNT_W-1:0] n_count;
    logic               n_last;

    t_cell_cmd          w_cmd;
    logic [KEY_W-1:0]   w_req_key;
    logic               w_accept;
    logic               w_slot_free;
    logic               w_full;

    t_link              w_link  [CAPACITY];
    t_link              w_left  [CAPACITY];
    t_link              w_right [CAPACITY];
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_first;
    logic [CAPACITY-1:0] w_final;
    logic [CAPACITY-1:0] w_in_use;

    logic               w_found;
    logic               w_any_match;
    logic [IDX_W-1:0]   w_start_idx;
    logic [IDX_W-1:0]   w_end_idx;
    logic [CNT_W-1:0]   w_cnt;
    logic [COUNT_W-1:0] w_cnt_sat;
    logic [ID_W-1:0]    w_list_sub;
    logic               w_list_last;
    logic               w_bind_ok;

    // handshake
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign w_full      = (r_used >= CNT_W'(CAPACITY));

    // compare against the incoming word, insert the held one
    assign w_req_key = (r_state == ST_IDLE) ? {i_req.event_req, i_req.plugin_id}
                                            : {r_event, r_id};

    // row of cells with boundary links at both ends
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_in_use[gi] = (CNT_W'(gi) < r_used);

            if (gi == 0) begin : g_lo
                assign w_left[gi] = '{key: '0, lt: 1'b1, match: 1'b0, tok: 1'b0};
            end else begin : g_mid_lo
                assign w_left[gi] = w_link[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_hi
                assign w_right[gi] = '{key: '0, lt: 1'b0, match: 1'b0, tok: 1'b0};
            end else begin : g_mid_hi
                assign w_right[gi] = w_link[gi+1];
            end

            spr_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_cmd),
                .i_in_use  (w_in_use[gi]),
                .i_req_key (w_req_key),
                .i_left    (w_left[gi]),
                .i_right   (w_right[gi]),
                .o_link    (w_link[gi]),
                .o_eq      (w_eq[gi]),
                .o_first   (w_first[gi]),
                .o_final   (w_final[gi])
            );
        end
    endgenerate

    // gather cell flags: hit, run of matching events, token output
    always_comb begin
        w_start_idx = '0;
        w_end_idx   = '0;
        w_list_sub  = '0;
        w_list_last = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_start_idx = w_start_idx | IDX_W'(i);
            end
            if (w_final[i]) begin
                w_end_idx = w_end_idx | IDX_W'(i);
            end
            if (w_link[i].tok) begin
                w_list_sub  = w_list_sub | w_link[i].key[ID_W-1:0];
                w_list_last = w_list_last | w_final[i];
            end
        end
    end

    assign w_found     = |w_eq;
    assign w_any_match = |w_first;
    assign w_cnt       = w_any_match ? (CNT_W'(w_end_idx) - CNT_W'(w_start_idx)
                                        + CNT_W'(1)) : '0;
    assign w_cnt_sat   = (int'(w_cnt) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(w_cnt);
    assign w_bind_ok   = (r_id != '0) && !w_found && !w_full;

    // commands to the row
    always_comb begin
        w_cmd.load      = w_accept;
        w_cmd.insert    = (r_state == ST_EVAL) && w_slot_free
                          && (r_action == ACT_BIND) && w_bind_ok;
        w_cmd.remove    = (r_state == ST_EVAL) && w_slot_free
                          && (r_action == ACT_UNBIND) && w_found;
        w_cmd.tok_start = (r_state == ST_EVAL) && (r_action == ACT_LIST);
        w_cmd.tok_shift = (r_state == ST_LIST) && w_slot_free;
    end

    // next state, fill count and result word
    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_status     = r_status;
        n_sub        = r_sub;
        n_item_valid = r_item_valid;
        n_count      = r_count;
        n_last       = r_last;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (w_slot_free) begin
                    n_sub        = '0;
                    n_item_valid = 1'b0;
                    n_count      = '0;
                    n_last       = 1'b1;
                    n_status     = STATUS_OK;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                    case (r_action)
                        ACT_BIND: begin
                            if (r_id == '0) begin
                                n_status = STATUS_INVALID;
                            end else if (w_found) begin
                                n_status = STATUS_DUP;
                            end else if (w_full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                n_used = r_used + CNT_W'(1);
                            end
                        end
                        ACT_UNBIND: begin
                            if (w_found) begin
                                n_used = r_used - CNT_W'(1);
                            end else begin
                                n_status = STATUS_NOTFOUND;
                            end
                        end
                        ACT_LIST: begin
                            // an empty list still gives one closing word
                            if (w_any_match) begin
                                n_out_valid = 1'b0;
                                n_state     = ST_LIST;
                            end
                        end
                        ACT_COUNT: begin
                            n_count = w_cnt_sat;
                        end
                        default: begin
                            n_status = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (w_slot_free) begin
                    n_status     = STATUS_OK;
                    n_sub        = w_list_sub;
                    n_item_valid = 1'b1;
                    n_count      = '0;
                    n_last       = w_list_last;
                    n_out_valid  = 1'b1;
                    if (w_list_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer, fill count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
        r_status     <= n_status;
        r_sub        <= n_sub;
        r_item_valid <= n_item_valid;
        r_count      <= n_count;
        r_last       <= n_last;
        if (w_accept) begin
            r_action <= i_req.action;
            r_event  <= i_req.event_req;
            r_id     <= i_req.plugin_id;
        end
    end

    // result channel
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_status;
    assign o_rsp.subscriber       = r_sub;
    assign o_rsp.item_valid       = r_item_valid;
    assign o_rsp.subscriber_count = r_count;
    assign o_rsp.last             = r_last;

endmodule
`default_nettype wire

// File: verif/tb_sorted_pair_registry_top.sv
// testbench: sorted pair registry driven with random bind, unbind, list and count requests
`timescale 1ns / 100ps
module tb_sorted_pair_registry_top;
    import spr_pkg::*;

    // one expected or observed result word
    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    subscriber;
        logic               item_valid;
        logic [COUNT_W-1:0] subscriber_count;
        logic               last;
    } t_registry_word;

    typedef enum int {
        ROUND_FILL,
        ROUND_MIXED,
        ROUND_DRAIN
    } t_round_kind;

    localparam int TOTAL_ITEMS  = 340;
    localparam int DRAIN_CYCLES = 40;

    // shadow of the pair table and the queue of results it predicts
    class registry_scoreboard;
        logic [KEY_W-1:0] pairs [CAPACITY];
        int unsigned      fill;
        t_registry_word   pending_q[$];
        int unsigned      faults;
        int unsigned      checked;

        function new();
            fill    = 0;
            faults  = 0;
            checked = 0;
        endfunction

        // first slot whose pair is not below the key
        function int unsigned slot_for(logic [KEY_W-1:0] key);
            int unsigned p;
            p = 0;
            while (p < fill && pairs[p] < key) p++;
            return p;
        endfunction

        function void push_word(t_status st, logic [ID_W-1:0] sub, logic iv,
                                logic [COUNT_W-1:0] cnt, logic lst);
            t_registry_word w;
            w.status           = st;
            w.subscriber       = sub;
            w.item_valid       = iv;
            w.subscriber_count = cnt;
            w.last             = lst;
            pending_q.insert(pending_q.size(), w);
        endfunction

        // accepted request: update the shadow table and queue its results
        function void note_request(t_action act, logic [EVENT_W-1:0] ev, logic [ID_W-1:0] id);
            logic [KEY_W-1:0] key;
            int unsigned      p;
            int unsigned      hits;
            logic [ID_W-1:0]  listed[$];
            key = {ev, id};
            p   = slot_for(key);
            case (act)
                ACT_BIND: begin
                    if (id == '0) begin
                        push_word(STATUS_INVALID, '0, 1'b0, '0, 1'b1);
                    end else if (p < fill && pairs[p] == key) begin
                        push_word(STATUS_DUP, '0, 1'b0, '0, 1'b1);
                    end else if (fill >= CAPACITY) begin
                        push_word(STATUS_FULL, '0, 1'b0, '0, 1'b1);
                    end else begin
                        for (int unsigned i = fill; i > p; i--) pairs[i] = pairs[i-1];
                        pairs[p] = key;
                        fill++;
                        push_word(STATUS_OK, '0, 1'b0, '0, 1'b1);
                    end
                end
                ACT_UNBIND: begin
                    if (id == '0 || p >= fill || pairs[p] != key) begin
                        push_word(STATUS_NOTFOUND, '0, 1'b0, '0, 1'b1);
                    end else begin
                        for (int unsigned i = p; i + 1 < fill; i++) pairs[i] = pairs[i+1];
                        fill--;
                        push_word(STATUS_OK, '0, 1'b0, '0, 1'b1);
                    end
                end
                ACT_LIST: begin
                    for (int unsigned i = 0; i < fill; i++)
                        if (pairs[i][KEY_W-1:ID_W] == ev)
                            listed.insert(listed.size(), pairs[i][ID_W-1:0]);
                    if (listed.size() == 0) begin
                        push_word(STATUS_OK, '0, 1'b0, '0, 1'b1);
                    end else begin
                        foreach (listed[i])
                            push_word(STATUS_OK, listed[i], 1'b1, '0, i == listed.size() - 1);
                    end
                end
                default: begin
                    hits = 0;
                    for (int unsigned i = 0; i < fill; i++)
                        if (pairs[i][KEY_W-1:ID_W] == ev) hits++;
                    if (hits > COUNT_MAX) hits = COUNT_MAX;
                    push_word(STATUS_OK, '0, 1'b0, hits[COUNT_W-1:0], 1'b1);
                end
            endcase
        endfunction

        // accepted result word: compare with the oldest prediction
        function void check_result(t_registry_word got);
            t_registry_word want;
            checked++;
            if (pending_q.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("result word %0d arrived with nothing outstanding: status %0d sub %h",
                             checked, got.status, got.subscriber);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status || got.subscriber !== want.subscriber ||
                got.item_valid !== want.item_valid ||
                got.subscriber_count !== want.subscriber_count || got.last !== want.last) begin
                faults++;
                if (faults <= 10)
                    $display({"result word %0d mismatch: expected st %0d sub %h iv %b cnt %0d last %b,",
                              " got st %0d sub %h iv %b cnt %0d last %b"}, checked,
                             want.status, want.subscriber, want.item_valid,
                             want.subscriber_count, want.last, got.status, got.subscriber,
                             got.item_valid, got.subscriber_count, got.last);
            end
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction

        // a pair now in the table, or a random one when the table is empty
        function logic [KEY_W-1:0] any_stored_pair();
            if (fill == 0) return KEY_W'($urandom);
            return pairs[$urandom_range(0, fill - 1)];
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    spr_req_if request_ch ();
    spr_rsp_if result_ch ();

    sorted_pair_registry_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (request_ch),
        .o_rsp   (result_ch)
    );

    registry_scoreboard registry = new();
    int unsigned        items_sent   = 0;
    int unsigned        results_seen = 0;
    logic [EVENT_W-1:0] hot_events [4];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard limit on the run
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // sender idles about 15 percent of the time, never in the calm stretch
    function automatic bit sender_pauses();
        if (items_sent >= 100 && items_sent < 170) return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    // offer one request word and wait until it is taken
    task automatic send_request(t_action act, logic [EVENT_W-1:0] ev, logic [ID_W-1:0] id);
        while (sender_pauses()) begin
            request_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        request_ch.valid     <= 1'b1;
        request_ch.action    <= act;
        request_ch.event_req <= ev;
        request_ch.plugin_id <= id;
        @(posedge i_clk);
        while (!request_ch.ready) @(posedge i_clk);
        registry.note_request(act, ev, id);
        items_sent++;
    endtask

    // id with the occasional zero or all-ones
    function automatic logic [ID_W-1:0] noisy_id();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 10) return '1;
        if (roll < 40) return ID_W'($urandom_range(1, 15));
        return ID_W'($urandom_range(1, 65535));
    endfunction

    // one random request shaped by the round kind
    task automatic random_request(t_round_kind kind);
        int unsigned        roll;
        t_action            act;
        logic [KEY_W-1:0]   stored;
        logic [EVENT_W-1:0] ev;
        logic [ID_W-1:0]    id;
        roll   = $urandom_range(0, 99);
        stored = registry.any_stored_pair();
        ev     = hot_events[$urandom_range(0, 3)];
        id     = noisy_id();
        case (kind)
            ROUND_FILL:
                act = roll < 70 ? ACT_BIND : roll < 80 ? ACT_UNBIND : roll < 90 ? ACT_LIST : ACT_COUNT;
            ROUND_DRAIN:
                act = roll < 60 ? ACT_UNBIND : roll < 75 ? ACT_BIND : roll < 90 ? ACT_LIST : ACT_COUNT;
            default:
                act = t_action'($urandom_range(0, 3));
        endcase
        // steer towards pairs and events that are present
        roll = $urandom_range(0, 99);
        if (act == ACT_UNBIND && roll < 75 && registry.fill != 0)
            {ev, id} = stored;
        else if (act == ACT_BIND && roll < 15)
            {ev, id} = stored;
        else if ((act == ACT_LIST || act == ACT_COUNT) && roll < 50)
            ev = stored[KEY_W-1:ID_W];
        if ($urandom_range(0, 99) < 8) ev = EVENT_W'($urandom_range(0, 255));
        send_request(act, ev, id);
    endtask

    // empty the table, then load every slot with one event and read it back
    task automatic flood_one_event();
        logic [KEY_W-1:0]   stored;
        logic [EVENT_W-1:0] ev;
        while (registry.fill != 0) begin
            stored = registry.any_stored_pair();
            send_request(ACT_UNBIND, stored[KEY_W-1:ID_W], stored[ID_W-1:0]);
        end
        ev = EVENT_W'($urandom_range(0, 255));
        while (registry.fill < CAPACITY)
            send_request(ACT_BIND, ev, ID_W'($urandom_range(1, 65535)));
        send_request(ACT_COUNT, ev, '0);
        send_request(ACT_LIST, ev, '0);
        // full table: a new pair is refused, a present one is still a duplicate
        send_request(ACT_BIND, ev + 8'd1, ID_W'($urandom_range(1, 65535)));
        stored = registry.any_stored_pair();
        send_request(ACT_BIND, stored[KEY_W-1:ID_W], stored[ID_W-1:0]);
        send_request(ACT_LIST, ev + 8'd1, '0);
        send_request(ACT_UNBIND, stored[KEY_W-1:ID_W], stored[ID_W-1:0]);
        send_request(ACT_LIST, ev, '0);
    endtask

    // request side: reset, directed words, then random rounds with one single-event flood
    initial begin : request_source
        t_round_kind kind;
        int unsigned len;
        bit          flooded;
        flooded = 1'b0;
        i_rst_n              <= 1'b0;
        request_ch.valid     <= 1'b0;
        request_ch.action    <= ACT_BIND;
        request_ch.event_req <= '0;
        request_ch.plugin_id <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, invalid id, duplicates, misses and field extremes
        send_request(ACT_COUNT,  8'h00, 16'h0000);
        send_request(ACT_LIST,   8'h00, 16'h0000);
        send_request(ACT_BIND,   8'h00, 16'h0000);
        send_request(ACT_UNBIND, 8'h00, 16'h0000);
        send_request(ACT_BIND,   8'hFF, 16'hFFFF);
        send_request(ACT_BIND,   8'hFF, 16'hFFFF);
        send_request(ACT_BIND,   8'h00, 16'h0001);
        send_request(ACT_BIND,   8'hFF, 16'h0001);
        send_request(ACT_BIND,   8'h00, 16'hFFFF);
        send_request(ACT_BIND,   8'h80, 16'h8000);
        send_request(ACT_BIND,   8'h7F, 16'h7FFF);
        send_request(ACT_BIND,   8'h55, 16'h5555);
        send_request(ACT_BIND,   8'hAA, 16'hAAAA);
        send_request(ACT_UNBIND, 8'hFF, 16'h0002);
        send_request(ACT_UNBIND, 8'h01, 16'h0001);
        send_request(ACT_LIST,   8'hFF, 16'h0000);
        send_request(ACT_LIST,   8'h00, 16'hFFFF);
        send_request(ACT_COUNT,  8'hFF, 16'hFFFF);
        send_request(ACT_UNBIND, 8'hFF, 16'hFFFF);
        send_request(ACT_LIST,   8'hFF, 16'h0000);
        send_request(ACT_COUNT,  8'h80, 16'h0000);
        send_request(ACT_UNBIND, 8'h00, 16'h0001);
        send_request(ACT_LIST,   8'h7F, 16'h0000);
        send_request(ACT_COUNT,  8'h00, 16'h0000);

        // random rounds, each round around a few hot events
        while (items_sent < TOTAL_ITEMS) begin
            if (!flooded && items_sent >= 180) begin
                flooded = 1'b1;
                flood_one_event();
            end
            foreach (hot_events[k])
                hot_events[k] = ($urandom_range(0, 9) == 0) ? (k[0] ? 8'hFF : 8'h00)
                                                            : EVENT_W'($urandom_range(0, 255));
            kind = t_round_kind'($urandom_range(0, 2));
            len  = $urandom_range(20, 50);
            repeat (len) random_request(kind);
        end
        request_ch.valid <= 1'b0;

        // let every predicted word arrive, then watch for strays
        while (registry.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (registry.faults == 0 && registry.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off, one calm stretch
    initial begin : result_sink
        int unsigned    hold_left;
        bit             held_once;
        t_registry_word got;
        hold_left = 0;
        held_once = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got.status           = t_status'(result_ch.status);
                got.subscriber       = result_ch.subscriber;
                got.item_valid       = result_ch.item_valid;
                got.subscriber_count = result_ch.subscriber_count;
                got.last             = result_ch.last;
                registry.check_result(got);
                results_seen++;
            end
            if (!held_once && results_seen >= 120) begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (results_seen >= 200 && results_seen < 320) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= 15);
            end
        end
    end

endmodule
